FILE: hw/rtl/lkt_pkg.sv
// ----------------------------------------------------------------------------
// lkt_pkg: shared definitions for the LRU keyed table
// Action codes, cell steering codes, control structs and default sizes.
// ----------------------------------------------------------------------------
package lkt_pkg;

	// Default sizes handed to the top level parameters.
	localparam int ENTRIES_DEF    = 16;
	localparam int KEY_BITS_DEF   = 32;
	localparam int VALUE_BITS_DEF = 32;

	// Capacity register and cause field widths.
	localparam int         CAP_BITS   = 5;
	localparam logic [4:0] CAP_RESET  = 5'd16;
	localparam int         CAUSE_BITS = 3;
	localparam logic [2:0] CAUSE_CAPACITY = 3'd0;

	// Action codes carried by an input item.
	localparam logic [1:0] ACT_GET    = 2'd0;
	localparam logic [1:0] ACT_PUT    = 2'd1;
	localparam logic [1:0] ACT_REMOVE = 2'd2;
	localparam logic [1:0] ACT_CLEAR  = 2'd3;

	// Where a cell takes its next content from.
	localparam logic [1:0] SEL_HOLD = 2'd0;
	localparam logic [1:0] SEL_PREV = 2'd1;
	localparam logic [1:0] SEL_NEXT = 2'd2;

	// Per-cell steering from the controller.
	typedef struct packed {
		logic [1:0] sel;
		logic       kill;
	} cell_ctl_t;

	// Outcome of the current item, used to build the result.
	typedef struct packed {
		logic found;
		logic evicted;
		logic cap_evict;
		logic get_hit;
		logic remove_hit;
	} ctrl_status_t;

endpackage

FILE: hw/rtl/lkt_cell.sv
// ----------------------------------------------------------------------------
// lkt_cell: one position of the recency chain
// Holds one entry, compares it against the lookup key and takes its next
// content from itself, the more recent neighbor or the older neighbor.
// ----------------------------------------------------------------------------
module lkt_cell #(
	parameter int KEY_BITS   = 32,
	parameter int VALUE_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lkt_pkg::cell_ctl_t    ctl,
	input  logic [KEY_BITS-1:0]   lookup_key,
	input  logic [KEY_BITS-1:0]   prev_key,
	input  logic [VALUE_BITS-1:0] prev_value,
	input  logic                  prev_valid,
	input  logic [KEY_BITS-1:0]   next_key,
	input  logic [VALUE_BITS-1:0] next_value,
	input  logic                  next_valid,
	output logic [KEY_BITS-1:0]   key_q,
	output logic [VALUE_BITS-1:0] value_q,
	output logic                  valid_q,
	output logic                  match
);
	import lkt_pkg::*;

	logic [KEY_BITS-1:0]   key_d;
	logic [VALUE_BITS-1:0] value_d;
	logic                  valid_d;

	// Only a live entry can match.
	assign match = valid_q && (key_q == lookup_key);

	// Select the source of the next content.
	always_comb begin
		key_d   = key_q;
		value_d = value_q;
		valid_d = valid_q;
		unique case (ctl.sel)
			SEL_PREV: begin
				key_d   = prev_key;
				value_d = prev_value;
				valid_d = prev_valid;
			end
			SEL_NEXT: begin
				key_d   = next_key;
				value_d = next_value;
				valid_d = next_valid;
			end
			default: begin
				key_d   = key_q;
				value_d = value_q;
				valid_d = valid_q;
			end
		endcase
		if (ctl.kill) begin
			valid_d = 1'b0;
		end
	end

	// The valid bit is control state and clears at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_d;
		end
	end

	// Key and value are payload and need no reset.
	always_ff @(posedge clk) begin
		key_q   <= key_d;
		value_q <= value_d;
	end

endmodule

FILE: hw/rtl/lkt_ctrl.sv
// ----------------------------------------------------------------------------
// lkt_ctrl: steering for the recency chain
// Decodes the action against the match and valid vectors, steers every
// cell and keeps the occupancy count.
// ----------------------------------------------------------------------------
module lkt_ctrl #(
	parameter int ENTRIES = 16,
	parameter int CW      = 5
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            fire,
	input  logic [1:0]                      action,
	input  logic [lkt_pkg::CAP_BITS-1:0]    capacity,
	input  logic [ENTRIES-1:0]              match_vec,
	input  logic [ENTRIES-1:0]              valid_vec,
	output lkt_pkg::cell_ctl_t              ctl [ENTRIES],
	output logic [ENTRIES-1:0]              last_vec,
	output logic [CW-1:0]                   occ,
	output lkt_pkg::ctrl_status_t           status
);
	import lkt_pkg::*;

	localparam int CMPW = (CW > CAP_BITS) ? CW : CAP_BITS;

	logic [CW-1:0]      occ_q;
	logic [ENTRIES-1:0] before_v;
	logic               hit;
	logic               cap_evict;
	logic [CMPW-1:0]    cap_ext;
	logic [CMPW-1:0]    cap_eff;
	logic [CMPW-1:0]    ent_ext;
	logic [CMPW-1:0]    occ_ext;

	assign occ = occ_q;
	assign hit = |match_vec;

	// Cells behind the hit, that is older than it.
	always_comb begin
		logic seen;
		seen = 1'b0;
		for (int i = 0; i < ENTRIES; i++) begin
			before_v[i] = seen;
			seen        = seen | match_vec[i];
		end
	end

	// The oldest live entry sits at the end of the valid prefix.
	assign last_vec = valid_vec & ~(valid_vec >> 1);

	// Clamp the capacity into one to ENTRIES and decide on an eviction.
	always_comb begin
		cap_ext = CMPW'(capacity);
		ent_ext = CMPW'(ENTRIES);
		occ_ext = CMPW'(occ_q);
		if (cap_ext == '0) begin
			cap_eff = CMPW'(1);
		end else if (cap_ext > ent_ext) begin
			cap_eff = ent_ext;
		end else begin
			cap_eff = cap_ext;
		end
	end

	assign cap_evict = (action == ACT_PUT) && !hit && (occ_ext >= cap_eff);

	// Outcome flags for the result of this item.
	always_comb begin
		status.found      = hit && (action != ACT_CLEAR);
		status.get_hit    = hit && (action == ACT_GET);
		status.remove_hit = hit && (action == ACT_REMOVE);
		status.cap_evict  = cap_evict;
		status.evicted    = cap_evict || status.remove_hit;
	end

	// Steer every cell of the chain.
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			ctl[i].sel  = SEL_HOLD;
			ctl[i].kill = 1'b0;
		end
		if (fire) begin
			unique case (action)
				ACT_GET, ACT_PUT: begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (hit) begin
							// Move the hit to the front, shift the younger ones back.
							if (!before_v[i]) begin
								ctl[i].sel = SEL_PREV;
							end
						end else if (action == ACT_PUT) begin
							// Insert at the front; the oldest drops out on eviction.
							ctl[i].sel = SEL_PREV;
							if (i > 0) begin
								ctl[i].kill = cap_evict && last_vec[i-1];
							end
						end
					end
				end
				ACT_REMOVE: begin
					// Close the gap behind the removed entry.
					for (int i = 0; i < ENTRIES; i++) begin
						if (hit && (before_v[i] || match_vec[i])) begin
							ctl[i].sel = SEL_NEXT;
						end
					end
				end
				default: begin
					for (int i = 0; i < ENTRIES; i++) begin
						ctl[i].kill = 1'b1;
					end
				end
			endcase
		end
	end

	// Occupancy count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			occ_q <= '0;
		end else if (fire) begin
			unique case (action)
				ACT_PUT: begin
					if (!hit && !cap_evict) begin
						occ_q <= CW'(occ_q + 1'b1);
					end
				end
				ACT_REMOVE: begin
					if (hit) begin
						occ_q <= CW'(occ_q - 1'b1);
					end
				end
				ACT_CLEAR: begin
					occ_q <= '0;
				end
				default: begin
					occ_q <= occ_q;
				end
			endcase
		end
	end

endmodule

FILE: hw/rtl/lru_keyed_table.sv
// ----------------------------------------------------------------------------
// lru_keyed_table: fully associative keyed table in recency order
// A chain of entry cells kept sorted from most to least recent, with get,
// put, remove and clear actions and eviction of the oldest entry.
// ----------------------------------------------------------------------------
// Usage:
// An item enters on in_valid/in_ready with action, key, value and reason.
// Every item gives exactly one result on out_valid/out_ready: found,
// read_value, evicted, evicted_key, evicted_value and evicted_cause.
// The result of an item is registered and shown from the cycle after the
// item is accepted. Throughput is one item per cycle while the receiver
// keeps out_ready high; the rate is set by the key compare in every
// cell and the one-step shift of the cell chain that follows it.
// A result waits in the output register while out_ready is low; in_ready
// stays high only when that register is empty or being emptied, so a
// stalled receiver holds back the sender and no result is lost.
// The capacity register is written with cfg_we/cfg_wdata; the user must
// write it only while idle; the block does not enforce this. A value
// of zero acts as one and a value above ENTRIES acts as ENTRIES. Reset
// empties the table at once (no clearing pass) and sets capacity to 16.
// ----------------------------------------------------------------------------
module lru_keyed_table #(
	parameter int ENTRIES    = lkt_pkg::ENTRIES_DEF,
	parameter int KEY_BITS   = lkt_pkg::KEY_BITS_DEF,
	parameter int VALUE_BITS = lkt_pkg::VALUE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [lkt_pkg::CAP_BITS-1:0]    cfg_wdata,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [KEY_BITS-1:0]             key,
	input  logic [VALUE_BITS-1:0]           value,
	input  logic [lkt_pkg::CAUSE_BITS-1:0]  reason,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic                            found,
	output logic [VALUE_BITS-1:0]           read_value,
	output logic                            evicted,
	output logic [KEY_BITS-1:0]             evicted_key,
	output logic [VALUE_BITS-1:0]           evicted_value,
	output logic [lkt_pkg::CAUSE_BITS-1:0]  evicted_cause
);
	import lkt_pkg::*;

	localparam int CW = $clog2(ENTRIES + 1);

	logic [CAP_BITS-1:0]   cap_q;
	logic                  fire;
	logic                  out_valid_q;

	logic [KEY_BITS-1:0]   cell_key   [ENTRIES];
	logic [VALUE_BITS-1:0] cell_value [ENTRIES];
	logic [ENTRIES-1:0]    valid_vec;
	logic [ENTRIES-1:0]    match_vec;
	logic [ENTRIES-1:0]    last_vec;
	cell_ctl_t             ctl [ENTRIES];
	ctrl_status_t          status;
	logic [CW-1:0]         occ;

	logic [VALUE_BITS-1:0] head_value;
	logic [KEY_BITS-1:0]   hit_key;
	logic [VALUE_BITS-1:0] hit_value;
	logic [KEY_BITS-1:0]   old_key;
	logic [VALUE_BITS-1:0] old_value;

	logic                  found_q;
	logic [VALUE_BITS-1:0] read_value_q;
	logic                  evicted_q;
	logic [KEY_BITS-1:0]   evicted_key_q;
	logic [VALUE_BITS-1:0] evicted_value_q;
	logic [CAUSE_BITS-1:0] evicted_cause_q;

	// Handshake: a new item enters when the result register frees up.
	assign in_ready  = !out_valid_q || out_ready;
	assign fire      = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// Capacity register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg_we) begin
			cap_q <= cfg_wdata;
		end
	end

	// The front cell takes the key with the new value on put, the old on get.
	assign head_value = (action == ACT_GET) ? hit_value : value;

	// Chain of cells, most recent at index zero.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		logic [KEY_BITS-1:0]   p_key;
		logic [VALUE_BITS-1:0] p_value;
		logic                  p_valid;
		logic [KEY_BITS-1:0]   n_key;
		logic [VALUE_BITS-1:0] n_value;
		logic                  n_valid;

		if (i == 0) begin : g_head
			assign p_key   = key;
			assign p_value = head_value;
			assign p_valid = 1'b1;
		end else begin : g_mid
			assign p_key   = cell_key[i-1];
			assign p_value = cell_value[i-1];
			assign p_valid = valid_vec[i-1];
		end

		if (i == ENTRIES - 1) begin : g_tail
			assign n_key   = '0;
			assign n_value = '0;
			assign n_valid = 1'b0;
		end else begin : g_body
			assign n_key   = cell_key[i+1];
			assign n_value = cell_value[i+1];
			assign n_valid = valid_vec[i+1];
		end

		lkt_cell #(
			.KEY_BITS   (KEY_BITS),
			.VALUE_BITS (VALUE_BITS)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl[i]),
			.lookup_key (key),
			.prev_key   (p_key),
			.prev_value (p_value),
			.prev_valid (p_valid),
			.next_key   (n_key),
			.next_value (n_value),
			.next_valid (n_valid),
			.key_q      (cell_key[i]),
			.value_q    (cell_value[i]),
			.valid_q    (valid_vec[i]),
			.match      (match_vec[i])
		);
	end

	lkt_ctrl #(
		.ENTRIES (ENTRIES),
		.CW      (CW)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.fire      (fire),
		.action    (action),
		.capacity  (cap_q),
		.match_vec (match_vec),
		.valid_vec (valid_vec),
		.ctl       (ctl),
		.last_vec  (last_vec),
		.occ       (occ),
		.status    (status)
	);

	// Pick the hit entry and the oldest entry out of the chain.
	always_comb begin
		hit_key   = '0;
		hit_value = '0;
		old_key   = '0;
		old_value = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			hit_key   = hit_key   | (cell_key[i]   & {KEY_BITS{match_vec[i]}});
			hit_value = hit_value | (cell_value[i] & {VALUE_BITS{match_vec[i]}});
			old_key   = old_key   | (cell_key[i]   & {KEY_BITS{last_vec[i]}});
			old_value = old_value | (cell_value[i] & {VALUE_BITS{last_vec[i]}});
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result payload, loaded when an item is accepted.
	always_ff @(posedge clk) begin
		if (fire) begin
			found_q      <= status.found;
			read_value_q <= status.get_hit ? hit_value : '0;
			evicted_q    <= status.evicted;
			priority if (status.remove_hit) begin
				evicted_key_q   <= hit_key;
				evicted_value_q <= hit_value;
				evicted_cause_q <= reason;
			end else if (status.cap_evict) begin
				evicted_key_q   <= old_key;
				evicted_value_q <= old_value;
				evicted_cause_q <= CAUSE_CAPACITY;
			end else begin
				evicted_key_q   <= '0;
				evicted_value_q <= '0;
				evicted_cause_q <= CAUSE_CAPACITY;
			end
		end
	end

	assign found         = found_q;
	assign read_value    = read_value_q;
	assign evicted       = evicted_q;
	assign evicted_key   = evicted_key_q;
	assign evicted_value = evicted_value_q;
	assign evicted_cause = evicted_cause_q;

	// Live entries always form an unbroken run from the front.
	a_valid_prefix: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot({1'b0, valid_vec} + {{ENTRIES{1'b0}}, 1'b1}))
		else $error("live entries do not form a prefix of the chain");

	// The occupancy count tracks the number of live cells.
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(occ))
		else $error("occupancy count disagrees with live cells");

	// Keys stay unique, so at most one cell matches.
	a_one_match: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(match_vec))
		else $error("more than one cell matches the key");

	// A nonzero cause only comes from a remove that found its key.
	a_cause_found: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (evicted_cause != CAUSE_CAPACITY)) |-> (found && evicted))
		else $error("remove cause reported without a hit");

endmodule
